### design/ctm_pkg.sv
// Shared types, constants and helpers for the cell template matcher.
package ctm_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int TILE_SIDE  = 26;
  localparam int CHANNELS   = 3;
  localparam int TILE_BYTES = TILE_SIDE * TILE_SIDE * CHANNELS;

  localparam int SLOT_W  = 4;
  localparam int LABEL_W = 5;
  localparam int POS_W   = 11;
  localparam int PIX_W   = 8;
  localparam int CNT_W   = 12;
  localparam int OCNT_W  = 11;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  localparam int WORD_W = NUM_SLOTS * PIX_W;

  localparam int GRP_SIZE = 4;
  localparam int NUM_GRP  = NUM_SLOTS / GRP_SIZE;

  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};
  localparam int                OUT_CNT_MAX = (1 << OCNT_W) - 1;
  localparam logic [OCNT_W-1:0] EMPTY_CNT   =
    OCNT_W'((TILE_BYTES > OUT_CNT_MAX) ? OUT_CNT_MAX : TILE_BYTES);
  localparam logic signed [LABEL_W-1:0] NO_LABEL = -5'sd1;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

  typedef struct packed {
    logic                      vld;
    op_t                       op;
    logic [SLOT_W-1:0]         slot;
    logic signed [LABEL_W-1:0] label;
    logic                      pos_ok;
    logic                      pos_zero;
    logic [PIX_W-1:0]          pix;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic                      ok;
    logic [CNT_W-1:0]          score;
    logic signed [LABEL_W-1:0] label;
  } cand_t;

  // a is the lower slot and keeps ties
  function automatic cand_t pick_best(input cand_t a, input cand_t b);
    if (b.ok && (!a.ok || (b.score < a.score))) begin
      return b;
    end
    return a;
  endfunction

endpackage

### design/ctm_store.sv
// Template memory: one word per tile byte position, one byte lane per slot.
module ctm_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic                       rd_en,
  input  logic [ctm_pkg::SLOT_W-1:0] slot,
  input  logic [ctm_pkg::POS_W-1:0]  addr,
  input  logic [ctm_pkg::PIX_W-1:0]  pix,
  output logic [ctm_pkg::WORD_W-1:0] q_r
);
  import ctm_pkg::*;

  logic [WORD_W-1:0] mem [TILE_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (slot == SLOT_W'(s)) begin
          mem[addr][s*PIX_W +: PIX_W] <= pix;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r <= mem[addr];
    end
  end

endmodule

### design/ctm_count.sv
// Per-slot mismatch counters, slot valid flags, labels and end-of-tile snapshot.
module ctm_count (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctm_pkg::item_t             itm,
  input  logic [ctm_pkg::WORD_W-1:0] q,
  output logic                       snap_vld_r,
  output ctm_pkg::cand_t             snap_r [ctm_pkg::NUM_SLOTS]
);
  import ctm_pkg::*;

  logic [NUM_SLOTS-1:0]      valid_r;
  logic [CNT_W-1:0]          cnt_r   [NUM_SLOTS];
  logic [CNT_W-1:0]          cnt_nxt [NUM_SLOTS];
  logic signed [LABEL_W-1:0] label_r [NUM_SLOTS];
  logic                      is_cls;
  logic                      is_last;
  logic                      load_zero;

  assign is_cls    = itm.vld && (itm.op == OP_CLASSIFY);
  assign is_last   = is_cls && itm.last;
  assign load_zero = itm.vld && (itm.op == OP_LOAD) && itm.pos_ok && itm.pos_zero;

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      cnt_nxt[s] = cnt_r[s];
      if (is_cls && itm.pos_ok && valid_r[s] && (q[s*PIX_W +: PIX_W] != itm.pix) &&
          (cnt_r[s] != CNT_MAX)) begin
        cnt_nxt[s] = cnt_r[s] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      snap_vld_r <= 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        cnt_r[s] <= '0;
      end
    end else begin
      snap_vld_r <= is_last;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        cnt_r[s] <= is_last ? '0 : cnt_nxt[s];
      end
      if (load_zero) begin
        valid_r[itm.slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_zero) begin
      label_r[itm.slot] <= itm.label;
    end
  end

  always_ff @(posedge clk) begin
    if (is_last) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        snap_r[s].ok    <= valid_r[s];
        snap_r[s].score <= cnt_nxt[s];
        snap_r[s].label <= label_r[s];
      end
    end
  end

  a_clear_after_tile: assert property (@(posedge clk) disable iff (!rst_n)
    is_last |=> (cnt_r[0] == '0) && snap_vld_r)
    else $error("counters not cleared after tile");

endmodule

### design/ctm_select.sv
// Two-stage minimum search over the slot snapshot; lowest slot wins ties.
module ctm_select (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           snap_vld,
  input  ctm_pkg::cand_t                 snap [ctm_pkg::NUM_SLOTS],
  output logic                           res_vld,
  output logic [ctm_pkg::OUT_DATA_W-1:0] res_data
);
  import ctm_pkg::*;

  cand_t grp_nxt [NUM_GRP];
  cand_t grp_r   [NUM_GRP];
  logic  grp_vld_r;
  cand_t best;
  logic [OCNT_W-1:0] count;

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_nxt[g] = snap[g*GRP_SIZE];
      for (int k = 1; k < GRP_SIZE; k++) begin
        grp_nxt[g] = pick_best(grp_nxt[g], snap[g*GRP_SIZE + k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_vld_r <= 1'b0;
    end else begin
      grp_vld_r <= snap_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_vld) begin
      grp_r <= grp_nxt;
    end
  end

  always_comb begin
    best = grp_r[0];
    for (int g = 1; g < NUM_GRP; g++) begin
      best = pick_best(best, grp_r[g]);
    end
    if (!best.ok) begin
      count = EMPTY_CNT;
    end else if (best.score > CNT_W'(OUT_CNT_MAX)) begin
      count = OCNT_W'(OUT_CNT_MAX);
    end else begin
      count = best.score[OCNT_W-1:0];
    end
  end

  assign res_vld  = grp_vld_r;
  assign res_data = {count, (best.ok ? best.label : NO_LABEL)};

endmodule

### design/ctm_outq.sv
// Result queue between the search pipeline and the output stream.
module ctm_outq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [ctm_pkg::OUT_DATA_W-1:0] push_data,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ctm_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ctm_pkg::*;

  logic [OUT_DATA_W-1:0] mem_r [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r;
  logic [QPTR_W-1:0]     rd_ptr_r;
  logic [QCNT_W-1:0]     cnt_r;
  logic                  pop;
  logic                  wr;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = mem_r[rd_ptr_r];
  assign pop        = out_tvalid && out_tready;
  assign wr         = push && (cnt_r != QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(wr) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != QCNT_W'(QDEPTH)))
    else $error("result pushed into full queue");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - QCNT_W'(1)))
    else $error("queue count wrong after pop");

endmodule

### design/cell_template_matcher.sv
// Cell template matcher top level: input decode, pipeline and result credit.
// Throughput: one transaction per cycle on in_ while in_tready is high;
//   a byte of a tile is compared against all sixteen slots at once from
//   one template memory word. Results pass s1_r, snap_r, grp_r and the queue.
// in_tready drops while eight results are queued or in flight.
// Reset clears slot valid flags, mismatch counters and the result queue;
//   template bytes and labels are undefined until loaded.
module cell_template_matcher (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // slot[3:0], slot_label[8:4], position[19:9], pixel_byte[27:20], zero[31:28]
  input  logic [ctm_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation[0]
  input  logic                           in_tuser,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // best_label[4:0], mismatch_count[15:5]
  output logic [ctm_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ctm_pkg::*;

  logic                      in_acc;
  logic [SLOT_W-1:0]         in_slot;
  logic signed [LABEL_W-1:0] in_label;
  logic [POS_W-1:0]          in_pos;
  logic [PIX_W-1:0]          in_pix;
  logic                      in_pos_ok;
  item_t                     s1_nxt;
  item_t                     s1_r;
  logic [WORD_W-1:0]         q;
  logic                      snap_vld;
  cand_t                     snap [NUM_SLOTS];
  logic                      res_vld;
  logic [OUT_DATA_W-1:0]     res_data;
  logic [QCNT_W-1:0]         credit_r;
  logic [QCNT_W-1:0]         credit_nxt;
  logic                      acc_last;
  logic                      out_pop;

  assign in_slot   = in_tdata[3:0];
  assign in_label  = in_tdata[8:4];
  assign in_pos    = in_tdata[19:9];
  assign in_pix    = in_tdata[27:20];
  assign in_pos_ok = (in_pos < POS_W'(TILE_BYTES));

  assign in_tready = (credit_r != QCNT_W'(QDEPTH));
  assign in_acc    = in_tvalid && in_tready;
  assign acc_last  = in_acc && (op_t'(in_tuser) == OP_CLASSIFY) && in_tlast;
  assign out_pop   = out_tvalid && out_tready;

  always_comb begin
    s1_nxt.vld      = in_acc;
    s1_nxt.op       = op_t'(in_tuser);
    s1_nxt.slot     = in_slot;
    s1_nxt.label    = in_label;
    s1_nxt.pos_ok   = in_pos_ok;
    s1_nxt.pos_zero = (in_pos == '0);
    s1_nxt.pix      = in_pix;
    s1_nxt.last     = in_tlast;
    credit_nxt      = credit_r + QCNT_W'(acc_last) - QCNT_W'(out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r     <= '0;
      credit_r <= '0;
    end else begin
      s1_r     <= s1_nxt;
      credit_r <= credit_nxt;
    end
  end

  ctm_store u_store (
    .clk   (clk),
    .wr_en (in_acc && (op_t'(in_tuser) == OP_LOAD) && in_pos_ok),
    .rd_en (in_acc && (op_t'(in_tuser) == OP_CLASSIFY) && in_pos_ok),
    .slot  (in_slot),
    .addr  (in_pos),
    .pix   (in_pix),
    .q_r   (q)
  );

  ctm_count u_count (
    .clk        (clk),
    .rst_n      (rst_n),
    .itm        (s1_r),
    .q          (q),
    .snap_vld_r (snap_vld),
    .snap_r     (snap)
  );

  ctm_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .snap_vld (snap_vld),
    .snap     (snap),
    .res_vld  (res_vld),
    .res_data (res_data)
  );

  ctm_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_vld),
    .push_data  (res_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= QCNT_W'(QDEPTH))
    else $error("result credit above queue depth");

  a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (credit_r != '0))
    else $error("result shown without outstanding credit");

  a_last_takes_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_last && !out_pop) |=> (credit_r == $past(credit_r) + QCNT_W'(1)))
    else $error("last byte did not reserve a result slot");

endmodule
